@@ rtl/dmarx_pkg.sv @@
// ----------------------------------------------------------------------------
// dmarx_pkg
// Shared codes and controller/datapath handshake types for the DMA receive
// ring tracker.
// ----------------------------------------------------------------------------
package dmarx_pkg;

  // item function codes
  localparam logic [1:0] FUNC_WRITE  = 2'd0;
  localparam logic [1:0] FUNC_REPORT = 2'd1;
  localparam logic [1:0] FUNC_WRAP   = 2'd2;
  localparam logic [1:0] FUNC_READ   = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_RESYNC    = 2'd1;
  localparam logic [1:0] STAT_ORDER_ERR = 2'd2;

  // controller -> datapath commands
  typedef struct packed {
    logic exec;      // item transfer accepted this cycle
    logic div_step;  // one remainder step of the resync modulo
    logic rd_step;   // deliver one ring byte
  } dmarx_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic need_div;  // accepted report resyncs the ring
    logic need_read; // accepted read delivers at least one byte
    logic div_last;  // final modulo step
    logic rd_last;   // final byte of the read
  } dmarx_sts_t;

endpackage

@@ rtl/dma_receive_ring_tracker_top.sv @@
// ----------------------------------------------------------------------------
// dma_receive_ring_tracker_top
// DMA receive ring tracker: ring store, read index, unread count and wrap
// balance, driven by DMA writes, position reports, wrap events and reads.
// ----------------------------------------------------------------------------
// Usage:
//   Input: an item transfer happens on a clock edge with start high and busy
//   low. in_func selects DMA byte write, position report, DMA wrap or read.
//   Results: each result is on the out_ ports for one cycle with out_valid
//   high; the receiver has no back-pressure and must take every transfer.
//   out_last marks the final result of an item.
//   Flow: writes, wraps, plain reports and empty reads give their single
//   result in the cycle after the transfer, and busy stays low, so one item per
//   cycle. A read of N bytes gives one byte per cycle, the first after the
//   controller's read state and the store read register; busy stays high
//   until the last byte goes out. A resyncing report runs a 9-step remainder
//   unit, with busy high until its result goes out.
//   Configuration: cfg_we/cfg_wdata write the ring size; write only while
//   idle. Reset (rst_n low, synchronous) clears the index, count and balance
//   and sets the ring size to 256; the store holds no data until written.
// ----------------------------------------------------------------------------
module dma_receive_ring_tracker_top import dmarx_pkg::*; #(
  parameter int RING_DEPTH = 256,
  parameter int MAX_READ   = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_func,
  input  logic [8:0] in_position,
  input  logic [7:0] in_write_byte,
  input  logic [6:0] in_request_count,
  input  logic       cfg_we,
  input  logic [8:0] cfg_wdata,
  output logic       out_valid,
  output logic [7:0] out_data_byte,
  output logic       out_byte_valid,
  output logic       out_last,
  output logic [1:0] out_status,
  output logic [8:0] out_available,
  output logic [7:0] out_overrun_bytes,
  output logic [6:0] out_read_count
);

  dmarx_cmd_t cmd;
  dmarx_sts_t sts;

  dmarx_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  dmarx_dp #(
    .RING_DEPTH (RING_DEPTH),
    .MAX_READ   (MAX_READ)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_func           (in_func),
    .in_position       (in_position),
    .in_write_byte     (in_write_byte),
    .in_request_count  (in_request_count),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_data_byte     (out_data_byte),
    .out_byte_valid    (out_byte_valid),
    .out_last          (out_last),
    .out_status        (out_status),
    .out_available     (out_available),
    .out_overrun_bytes (out_overrun_bytes),
    .out_read_count    (out_read_count)
  );

endmodule

@@ rtl/dmarx_dp.sv @@
// ----------------------------------------------------------------------------
// dmarx_dp
// Datapath: ring store, read index, unread count, wrap balance, resync
// remainder unit, read byte counter and the result registers.
// ----------------------------------------------------------------------------
module dmarx_dp import dmarx_pkg::*; #(
  parameter int RING_DEPTH = 256,
  parameter int MAX_READ   = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  dmarx_cmd_t cmd,
  output dmarx_sts_t sts,
  input  logic [1:0] in_func,
  input  logic [8:0] in_position,
  input  logic [7:0] in_write_byte,
  input  logic [6:0] in_request_count,
  input  logic       cfg_we,
  input  logic [8:0] cfg_wdata,
  output logic       out_valid,
  output logic [7:0] out_data_byte,
  output logic       out_byte_valid,
  output logic       out_last,
  output logic [1:0] out_status,
  output logic [8:0] out_available,
  output logic [7:0] out_overrun_bytes,
  output logic [6:0] out_read_count
);

  // ring size register is 9 bits, so no more than 511 entries are reachable
  localparam int RS_MAX = (RING_DEPTH > 511) ? 511 : RING_DEPTH;
  localparam int IW     = $clog2(RS_MAX);
  localparam int CW     = $clog2(MAX_READ + 1);

  function automatic logic [8:0] clamp_cnt(input logic signed [10:0] v);
    logic [8:0] r;
    if (v < 0) begin
      r = 9'd0;
    end else if (v > 11'sd511) begin
      r = 9'd511;
    end else begin
      r = v[8:0];
    end
    return r;
  endfunction

  // state registers
  logic [8:0]        cfg_r;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [8:0]        unread_r, unread_nxt;
  logic signed [7:0] bal_r, bal_nxt;
  logic [8:0]        div_q_r, div_q_nxt;
  logic [8:0]        div_rem_r, div_rem_nxt;
  logic [3:0]        div_cnt_r, div_cnt_nxt;
  logic [CW-1:0]     rd_cnt_r, rd_cnt_nxt;
  logic [CW-1:0]     nrd_r, nrd_nxt;
  logic [7:0]        lost_r, lost_nxt;

  // result registers
  logic       out_valid_r, out_valid_nxt;
  logic       out_bv_r, out_bv_nxt;
  logic       out_last_r, out_last_nxt;
  logic [1:0] out_status_r, out_status_nxt;
  logic [8:0] out_avail_r, out_avail_nxt;
  logic [7:0] out_lost_r, out_lost_nxt;
  logic [6:0] out_rc_r, out_rc_nxt;

  // ring store
  logic [7:0] mem [RS_MAX];
  logic [7:0] mem_q_r;

  // effective ring size
  logic [8:0] rs;
  assign rs = (cfg_r == 9'd0) ? 9'd1 :
              (cfg_r > 9'(RS_MAX)) ? 9'(RS_MAX) : cfg_r;

  // position report arithmetic
  logic [8:0]         idx9;
  logic               st_lt_p, p_lt_st, resync;
  logic signed [10:0] wrap_diff, lin_diff;
  assign idx9      = 9'(idx_r);
  assign st_lt_p   = idx9 < in_position;
  assign p_lt_st   = in_position < idx9;
  assign wrap_diff = $signed({2'b00, rs}) - $signed({2'b00, idx9})
                   + $signed({2'b00, in_position});
  assign lin_diff  = $signed({2'b00, in_position}) - $signed({2'b00, idx9});
  assign resync    = (bal_r >= 8'sd2) || ((bal_r == 8'sd1) && st_lt_p);

  // read request sizing
  logic [8:0]    lost_full;
  logic [7:0]    lost_sat;
  logic [6:0]    req_c, n0, n7;
  logic [CW-1:0] n_rd;
  assign lost_full = (unread_r > rs) ? (unread_r - rs) : 9'd0;
  assign lost_sat  = lost_full[8] ? 8'd255 : lost_full[7:0];
  assign req_c     = (in_request_count > 7'(MAX_READ)) ? 7'(MAX_READ) : in_request_count;
  assign n0        = (unread_r < 9'(req_c)) ? unread_r[6:0] : req_c;
  assign n7        = (9'(n0) > rs) ? rs[6:0] : n0;
  assign n_rd      = CW'(n7);

  // one restoring remainder step
  logic [9:0] div_trial, div_sub;
  logic [8:0] div_rem_new;
  assign div_trial   = {div_rem_r, div_q_r[8]};
  assign div_sub     = div_trial - {1'b0, rs};
  assign div_rem_new = (div_trial >= {1'b0, rs}) ? div_sub[8:0] : div_trial[8:0];

  // read index advance
  logic [IW:0] idx_inc;
  logic        idx_wrap;
  assign idx_inc  = {1'b0, idx_r} + 1'b1;
  assign idx_wrap = 10'(idx_inc) >= 10'(rs);

  // status to controller
  always_comb begin
    sts.need_div  = (in_func == FUNC_REPORT) && resync;
    sts.need_read = (in_func == FUNC_READ) && (n_rd != '0);
    sts.div_last  = div_cnt_r == 4'd0;
    sts.rd_last   = rd_cnt_r == CW'(1);
  end

  // next-state logic
  always_comb begin
    logic       emit;
    logic [1:0] emit_status;
    logic [7:0] emit_lost;

    idx_nxt        = idx_r;
    unread_nxt     = unread_r;
    bal_nxt        = bal_r;
    div_q_nxt      = div_q_r;
    div_rem_nxt    = div_rem_r;
    div_cnt_nxt    = div_cnt_r;
    rd_cnt_nxt     = rd_cnt_r;
    nrd_nxt        = nrd_r;
    lost_nxt       = lost_r;
    out_valid_nxt  = 1'b0;
    out_bv_nxt     = out_bv_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    out_avail_nxt  = out_avail_r;
    out_lost_nxt   = out_lost_r;
    out_rc_nxt     = out_rc_r;
    emit           = 1'b0;
    emit_status    = STAT_OK;
    emit_lost      = 8'd0;

    if (cmd.exec) begin
      unique case (in_func)
        FUNC_WRITE: begin
          emit = 1'b1;
        end
        FUNC_WRAP: begin
          if (bal_r < 8'sd127) begin
            bal_nxt = bal_r + 8'sd1;
          end
          emit = 1'b1;
        end
        FUNC_REPORT: begin
          if (resync) begin
            div_q_nxt   = in_position;
            div_rem_nxt = 9'd0;
            div_cnt_nxt = 4'd8;
          end else if (bal_r == 8'sd1) begin
            unread_nxt = clamp_cnt(wrap_diff);
            emit       = 1'b1;
          end else if (bal_r < 8'sd0) begin
            if (p_lt_st) begin
              emit_status = STAT_ORDER_ERR;
            end else begin
              unread_nxt = clamp_cnt(lin_diff);
            end
            emit = 1'b1;
          end else begin
            unread_nxt = p_lt_st ? clamp_cnt(wrap_diff) : clamp_cnt(lin_diff);
            emit       = 1'b1;
          end
        end
        FUNC_READ: begin
          unread_nxt = unread_r - 9'(n0);
          lost_nxt   = lost_sat;
          nrd_nxt    = n_rd;
          rd_cnt_nxt = n_rd;
          if (n_rd == '0) begin
            emit      = 1'b1;
            emit_lost = lost_sat;
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end

    // resync: remainder of position by ring size, one bit a cycle
    if (cmd.div_step) begin
      div_q_nxt   = {div_q_r[7:0], 1'b0};
      div_rem_nxt = div_rem_new;
      div_cnt_nxt = div_cnt_r - 4'd1;
      if (div_cnt_r == 4'd0) begin
        idx_nxt     = IW'(div_rem_new);
        bal_nxt     = 8'sd0;
        emit        = 1'b1;
        emit_status = STAT_RESYNC;
      end
    end

    // single-result transfer
    if (emit) begin
      out_valid_nxt  = 1'b1;
      out_bv_nxt     = 1'b0;
      out_last_nxt   = 1'b1;
      out_status_nxt = emit_status;
      out_avail_nxt  = unread_nxt;
      out_lost_nxt   = emit_lost;
      out_rc_nxt     = 7'd0;
    end

    // byte delivery, data comes from the store read register
    if (cmd.rd_step) begin
      out_valid_nxt  = 1'b1;
      out_bv_nxt     = 1'b1;
      out_last_nxt   = rd_cnt_r == CW'(1);
      out_status_nxt = STAT_OK;
      out_avail_nxt  = unread_r;
      out_lost_nxt   = lost_r;
      out_rc_nxt     = 7'(nrd_r);
      rd_cnt_nxt     = rd_cnt_r - CW'(1);
      if (idx_wrap) begin
        idx_nxt = '0;
        if (bal_r > -8'sd127) begin
          bal_nxt = bal_r - 8'sd1;
        end
      end else begin
        idx_nxt = idx_inc[IW-1:0];
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= 9'd256;
      idx_r       <= '0;
      unread_r    <= 9'd0;
      bal_r       <= 8'sd0;
      out_valid_r <= 1'b0;
      div_cnt_r   <= 4'd0;
      rd_cnt_r    <= '0;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      idx_r       <= idx_nxt;
      unread_r    <= unread_nxt;
      bal_r       <= bal_nxt;
      out_valid_r <= out_valid_nxt;
      div_cnt_r   <= div_cnt_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    div_q_r      <= div_q_nxt;
    div_rem_r    <= div_rem_nxt;
    nrd_r        <= nrd_nxt;
    lost_r       <= lost_nxt;
    out_bv_r     <= out_bv_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
    out_avail_r  <= out_avail_nxt;
    out_lost_r   <= out_lost_nxt;
    out_rc_r     <= out_rc_nxt;
  end

  // ring store: DMA write port, registered read port
  always_ff @(posedge clk) begin
    if (cmd.exec && (in_func == FUNC_WRITE) && (in_position < rs)) begin
      mem[in_position[IW-1:0]] <= in_write_byte;
    end
    if (cmd.rd_step) begin
      mem_q_r <= mem[idx_r];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_data_byte     = out_bv_r ? mem_q_r : 8'd0;
  assign out_byte_valid    = out_bv_r;
  assign out_last          = out_last_r;
  assign out_status        = out_status_r;
  assign out_available     = out_avail_r;
  assign out_overrun_bytes = out_lost_r;
  assign out_read_count    = out_rc_r;

endmodule

@@ rtl/dmarx_ctrl.sv @@
// ----------------------------------------------------------------------------
// dmarx_ctrl
// Controller: accepts items, sequences the resync remainder steps and the
// byte delivery of read requests.
// ----------------------------------------------------------------------------
module dmarx_ctrl import dmarx_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  output dmarx_cmd_t cmd,
  input  dmarx_sts_t sts
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  // commands
  always_comb begin
    cmd.exec     = (state_r == ST_IDLE) && start;
    cmd.div_step = state_r == ST_DIV;
    cmd.rd_step  = state_r == ST_READ;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (sts.need_div) begin
            state_nxt = ST_DIV;
          end else if (sts.need_read) begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_DIV: begin
        if (sts.div_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_READ: begin
        if (sts.rd_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered busy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= state_nxt != ST_IDLE;
    end
  end

  assign busy = busy_r;

endmodule

@@ tb/sv/tb_dma_receive_ring_tracker_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dma_receive_ring_tracker_top
// Self-checking bench for the DMA receive ring tracker. The ring is first cut
// to 32 bytes and those entries are filled with DMA writes; no later setting
// lets a read reach past them. After that come a directed pass over the
// corner cases, a short pass on a ring size above the store, one on the
// one-byte ring, and random DMA traffic at several ring sizes. Each accepted
// item goes through a cycle-free predictor. Every result strobe is checked
// field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_dma_receive_ring_tracker_top;
  import dmarx_pkg::*;

  localparam int RING_DEPTH = 256;
  localparam int MAX_READ   = 64;
  localparam int FILL_SIZE  = 32;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [1:0] func;
    logic [8:0] position;
    logic [7:0] write_byte;
    logic [6:0] request_count;
  } ring_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
    logic [1:0] status;
    logic [8:0] available;
    logic [7:0] overrun_bytes;
    logic [6:0] read_count;
  } ring_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] in_func = FUNC_WRITE;
  logic [8:0] in_position = '0;
  logic [7:0] in_write_byte = '0;
  logic [6:0] in_request_count = '0;
  logic       cfg_we = 1'b0;
  logic [8:0] cfg_wdata = '0;
  logic       out_valid;
  logic [7:0] out_data_byte;
  logic       out_byte_valid;
  logic       out_last;
  logic [1:0] out_status;
  logic [8:0] out_available;
  logic [7:0] out_overrun_bytes;
  logic [6:0] out_read_count;

  dma_receive_ring_tracker_top #(
    .RING_DEPTH(RING_DEPTH),
    .MAX_READ  (MAX_READ)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_position      (in_position),
    .in_write_byte    (in_write_byte),
    .in_request_count (in_request_count),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_data_byte    (out_data_byte),
    .out_byte_valid   (out_byte_valid),
    .out_last         (out_last),
    .out_status       (out_status),
    .out_available    (out_available),
    .out_overrun_bytes(out_overrun_bytes),
    .out_read_count   (out_read_count)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predicted ring state
  logic [7:0] ring_mem [RING_DEPTH];
  int         rd_idx;
  int         unread;
  int         balance;
  logic [8:0] ring_size_reg;

  ring_item_t   dma_items[$];
  ring_result_t due_results[$];

  int  fail_count = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  resync_count = 0;
  int  order_err_count = 0;
  int  ring_settings = 0;
  int  cycle_count = 0;
  bit  quiet = 1'b0;
  bit  idle_mode = 1'b1;
  int  gap_left = 0;
  int  wr_ptr;
  ring_item_t cur_item;

  function automatic int ring_eff();
    if (ring_size_reg == 0) return 1;
    if (ring_size_reg > RING_DEPTH) return RING_DEPTH;
    return int'(ring_size_reg);
  endfunction

  function automatic int clamp_unread(int v);
    if (v < 0) return 0;
    if (v > 511) return 511;
    return v;
  endfunction

  // Apply one accepted transfer to the predicted state, queue its results
  task automatic apply_ring_item(ring_item_t it);
    int rs, p, st, lost, req, n;
    ring_result_t r;
    rs = ring_eff();
    r = '0;
    r.last = 1'b1;
    r.status = STAT_OK;
    case (it.func)
      FUNC_WRITE: begin
        if (int'(it.position) < rs) ring_mem[it.position[7:0]] = it.write_byte;
        r.available = unread[8:0];
        due_results.push_back(r);
      end
      FUNC_REPORT: begin
        p = int'(it.position);
        st = rd_idx;
        if (balance >= 2 || (balance == 1 && st < p)) begin
          // writer lapped the reader: jump to the write position
          balance = 0;
          rd_idx = p % rs;
          r.status = STAT_RESYNC;
          resync_count++;
        end else if (balance == 1) begin
          unread = clamp_unread(rs - st + p);
        end else if (balance < 0) begin
          if (p < st) begin
            r.status = STAT_ORDER_ERR;
            order_err_count++;
          end else begin
            unread = clamp_unread(p - st);
          end
        end else if (p < st) begin
          unread = clamp_unread(rs - st + p);
        end else begin
          unread = clamp_unread(p - st);
        end
        r.available = unread[8:0];
        due_results.push_back(r);
      end
      FUNC_WRAP: begin
        if (balance < 127) balance++;
        r.available = unread[8:0];
        due_results.push_back(r);
      end
      default: begin
        lost = (unread > rs) ? unread - rs : 0;
        if (lost > 255) lost = 255;
        req = (int'(it.request_count) > MAX_READ) ? MAX_READ : int'(it.request_count);
        n = (unread < req) ? unread : req;
        unread -= n;
        if (n > rs) n = rs;
        r.available = unread[8:0];
        r.overrun_bytes = lost[7:0];
        if (n == 0) begin
          due_results.push_back(r);
        end else begin
          for (int i = 0; i < n; i++) begin
            r.data_byte = ring_mem[rd_idx];
            r.byte_valid = 1'b1;
            r.last = (i == n - 1);
            r.read_count = n[6:0];
            due_results.push_back(r);
            rd_idx++;
            if (rd_idx >= rs) begin
              rd_idx = 0;
              if (balance > -127) balance--;
            end
          end
        end
      end
    endcase
  endtask

  // Driver: feeds queued items, with random idle bursts between transfers unless quiet
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        apply_ring_item(cur_item);
        items_sent++;
        if ($urandom_range(0, 15) == 0) idle_mode = !idle_mode;
        if (!quiet && idle_mode && $urandom_range(0, 2) == 0)
          gap_left = $urandom_range(1, 4);
      end
      if (start && busy) begin
        // hold the item until the block takes it
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (dma_items.size() > 0) begin
        cur_item = dma_items.pop_front();
        in_func <= cur_item.func;
        in_position <= cur_item.position;
        in_write_byte <= cur_item.write_byte;
        in_request_count <= cur_item.request_count;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  function automatic void check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      fail_count++;
    end
  endfunction

  // Monitor: every strobe is one result transfer
  always @(posedge clk) begin
    ring_result_t e;
    if (rst_n && out_valid) begin
      results_seen++;
      if (due_results.size() == 0) begin
        $error("result transfer with no result pending");
        fail_count++;
      end else begin
        e = due_results.pop_front();
        check_field("data_byte", e.data_byte, out_data_byte);
        check_field("byte_valid", e.byte_valid, out_byte_valid);
        check_field("last", e.last, out_last);
        check_field("status", e.status, out_status);
        check_field("available", e.available, out_available);
        check_field("overrun_bytes", e.overrun_bytes, out_overrun_bytes);
        check_field("read_count", e.read_count, out_read_count);
      end
    end
  end

  // Hang guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic queue_item(logic [1:0] f, logic [8:0] p, logic [7:0] b, logic [6:0] q);
    ring_item_t it;
    it.func = f;
    it.position = p;
    it.write_byte = b;
    it.request_count = q;
    dma_items.push_back(it);
  endtask

  // Wait until every queued item is taken and every result has come back
  task automatic wait_idle();
    @(negedge clk);
    while (dma_items.size() != 0 || start || due_results.size() != 0) @(negedge clk);
  endtask

  task automatic set_ring(logic [8:0] v);
    wait_idle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    ring_size_reg = v;
    ring_settings++;
    @(negedge clk);
  endtask

  // DMA write pointer moves on; a wrap event goes out at the ring end
  task automatic step_wr_ptr(int sz);
    wr_ptr++;
    if (wr_ptr >= sz) begin
      wr_ptr = 0;
      queue_item(FUNC_WRAP, '0, '0, '0);
    end
  endtask

  // Mostly well-formed DMA traffic with random content, some noise
  task automatic dma_traffic(int n_items);
    int sz, base, k;
    sz = ring_eff();
    wr_ptr = 0;
    base = dma_items.size() + items_sent;
    while (dma_items.size() + items_sent - base < n_items) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          k = $urandom_range(1, 6);
          for (int i = 0; i < k; i++) begin
            queue_item(FUNC_WRITE, wr_ptr[8:0], 8'($urandom), '0);
            step_wr_ptr(sz);
          end
        end
        2: begin
          // DMA moved on without the bytes being tracked here
          k = $urandom_range(1, sz);
          for (int i = 0; i < k; i++) step_wr_ptr(sz);
        end
        3, 4: queue_item(FUNC_REPORT, wr_ptr[8:0], '0, '0);
        5, 6: queue_item(FUNC_READ, '0, '0, 7'($urandom_range(0, MAX_READ)));
        7: queue_item(FUNC_READ, '0, '0, 7'($urandom_range(0, 127)));
        8: queue_item(2'($urandom), 9'($urandom), 8'($urandom), 7'($urandom));
        default: begin
          // spurious wrap or a stray position report
          if ($urandom_range(0, 1) == 1) queue_item(FUNC_WRAP, '0, '0, '0);
          else queue_item(FUNC_REPORT, 9'($urandom_range(0, 511)), '0, '0);
        end
      endcase
    end
  endtask

  initial begin
    for (int i = 0; i < RING_DEPTH; i++) ring_mem[i] = '0;
    rd_idx = 0;
    unread = 0;
    balance = 0;
    ring_size_reg = 9'd256;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Small ring, filled so that no read hits an unwritten entry
    set_ring(9'(FILL_SIZE));
    for (int i = 0; i < FILL_SIZE; i++) queue_item(FUNC_WRITE, 9'(i), 8'($urandom), '0);
    wait_idle();

    // Directed corner cases on the 32-byte ring
    queue_item(FUNC_READ, '0, '0, 7'd0);           // empty read
    queue_item(FUNC_READ, '0, '0, 7'd127);         // empty read, oversized request
    queue_item(FUNC_WRITE, 9'd32, 8'hAA, '0);      // outside ring, ignored
    queue_item(FUNC_WRITE, 9'd511, 8'h55, '0);     // outside ring, ignored
    queue_item(FUNC_WRITE, 9'd0, 8'hFF, '0);
    queue_item(FUNC_WRITE, 9'd31, 8'h00, '0);
    queue_item(FUNC_REPORT, 9'd511, '0, '0);       // count at top of range
    queue_item(FUNC_READ, '0, '0, 7'd127);         // overrun saturates, ring-limited read
    queue_item(FUNC_REPORT, 9'd20, '0, '0);        // negative balance, position ahead
    queue_item(FUNC_READ, '0, '0, 7'd8);
    queue_item(FUNC_REPORT, 9'd4, '0, '0);         // DMA order error
    queue_item(FUNC_REPORT, 9'd20, '0, '0);
    queue_item(FUNC_WRAP, '0, '0, '0);
    queue_item(FUNC_WRAP, '0, '0, '0);
    queue_item(FUNC_REPORT, 9'd4, '0, '0);         // single wrap, position behind
    queue_item(FUNC_REPORT, 9'd20, '0, '0);        // stale single wrap: resync
    queue_item(FUNC_WRAP, '0, '0, '0);
    queue_item(FUNC_WRAP, '0, '0, '0);
    queue_item(FUNC_WRAP, '0, '0, '0);
    queue_item(FUNC_REPORT, 9'd300, '0, '0);       // lapped: resync modulo ring size
    queue_item(FUNC_READ, '0, '0, 7'd64);          // reader wraps past the ring end

    // Ring size above the store acts as the whole store; no reads here
    set_ring(9'd511);
    queue_item(FUNC_WRITE, 9'd300, 8'h5A, '0);     // outside the clamped ring
    queue_item(FUNC_WRAP, '0, '0, '0);
    queue_item(FUNC_REPORT, 9'd3, '0, '0);         // count taken from the clamped size

    // One-byte ring (size 0 acts as 1)
    set_ring(9'd0);
    queue_item(FUNC_READ, '0, '0, 7'd64);          // index past the shrunk ring
    queue_item(FUNC_WRAP, '0, '0, '0);
    queue_item(FUNC_WRAP, '0, '0, '0);
    queue_item(FUNC_REPORT, 9'd0, '0, '0);         // single wrap, position not ahead
    queue_item(FUNC_REPORT, 9'd511, '0, '0);       // stale single wrap: resync
    queue_item(FUNC_READ, '0, '0, 7'd1);

    // Random traffic over a spread of ring sizes
    set_ring(9'd17);
    dma_traffic(12);
    set_ring(9'($urandom_range(2, FILL_SIZE)));
    dma_traffic(12);

    // Last stretch back-to-back on the filled ring
    set_ring(9'(FILL_SIZE));
    quiet = 1'b1;
    dma_traffic(14);

    wait_idle();
    repeat (20) @(posedge clk);
    $display("summary: %0d items, %0d results over %0d ring size settings",
             items_sent, results_seen, ring_settings);
    $display("summary: %0d resyncs and %0d order errors predicted",
             resync_count, order_err_count);
    if (fail_count == 0 && due_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
